// File: rtl/ppia_pkg.sv
// Shared types and constants for the point-in-outline / shoelace area block.
// Used by every module under rtl/. No dependencies.
package ppia_pkg;

  localparam int CoordW      = 24;
  localparam int MaxVertices = 4096;
  localparam int MinVertices = 3;
  localparam int CountW      = $clog2(MaxVertices + 2);
  localparam int DiffW       = CoordW + 1;
  localparam int CrossW      = 2 * DiffW;
  localparam int ProdW       = 2 * CoordW;
  localparam int TermW       = ProdW + 1;
  localparam int SumW        = 61;
  localparam int AreaW       = 60;
  localparam int QDepth      = 4;
  localparam int PtrW        = $clog2(QDepth);
  localparam int LvlW        = $clog2(QDepth + 1);

  typedef logic signed [CoordW-1:0] coord_t;

  // One queued request: current vertex, previous and first vertex, probe, flags.
  typedef struct packed {
    coord_t cur_x;
    coord_t cur_y;
    coord_t prv_x;
    coord_t prv_y;
    coord_t fst_x;
    coord_t fst_y;
    coord_t prb_x;
    coord_t prb_y;
    logic   edge_en;
    logic   last;
    logic   few;
    logic   ovf;
  } entry_t;

  typedef struct packed {
    logic edge_en;
    logic last;
    logic few;
    logic ovf;
  } flags_t;

  // Edge from b to a, probe p.
  typedef struct packed {
    coord_t bx;
    coord_t by;
    coord_t ax;
    coord_t ay;
    coord_t px;
    coord_t py;
  } edge_ops_t;

  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
  } edge_ld_t;

  typedef struct packed {
    logic                    toggle;
    logic signed [TermW-1:0] term;
  } edge_res_t;

endpackage

// File: rtl/ppia_front.sv
// Front end: takes vertices, tracks outline position and overflow, queues edge work.
// Depends on ppia_pkg.
module ppia_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  ppia_pkg::coord_t vertex_along_i,
  input  ppia_pkg::coord_t vertex_across_i,
  input  ppia_pkg::coord_t probe_along_i,
  input  ppia_pkg::coord_t probe_across_i,
  input  logic             last_vertex_i,
  output logic             push_o,
  output ppia_pkg::entry_t push_data_o,
  input  logic             full_i
);
  import ppia_pkg::*;

  logic [CountW-1:0] cnt_q, cnt_d, cnt_n;
  logic              ovf_q, ovf_d, ovf_n;
  coord_t            fst_x_q, fst_y_q, prv_x_q, prv_y_q, prb_x_q, prb_y_q;
  logic              take, capture, edge_en;

  assign in_stall_o = full_i;
  assign take       = in_valid_i && !full_i;

  always_comb begin
    capture = 1'b0;
    edge_en = 1'b0;
    cnt_n   = cnt_q;
    ovf_n   = ovf_q;
    if (!ovf_q) begin
      capture = (cnt_q == '0);
      edge_en = (cnt_q != '0) && (cnt_q < CountW'(MaxVertices));
      cnt_n   = cnt_q + 1'b1;
      ovf_n   = (cnt_n > CountW'(MaxVertices));
    end
  end

  always_comb begin
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (take) begin
      if (last_vertex_i) begin
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        cnt_d = cnt_n;
        ovf_d = ovf_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && capture) begin
      fst_x_q <= vertex_along_i;
      fst_y_q <= vertex_across_i;
      prb_x_q <= probe_along_i;
      prb_y_q <= probe_across_i;
    end
    if (take && !ovf_n) begin
      prv_x_q <= vertex_along_i;
      prv_y_q <= vertex_across_i;
    end
  end

  // Only edges and outline ends need the back end.
  assign push_o = take && (edge_en || last_vertex_i);

  always_comb begin
    push_data_o.cur_x   = vertex_along_i;
    push_data_o.cur_y   = vertex_across_i;
    push_data_o.prv_x   = prv_x_q;
    push_data_o.prv_y   = prv_y_q;
    push_data_o.fst_x   = fst_x_q;
    push_data_o.fst_y   = fst_y_q;
    push_data_o.prb_x   = prb_x_q;
    push_data_o.prb_y   = prb_y_q;
    push_data_o.edge_en = edge_en;
    push_data_o.last    = last_vertex_i;
    push_data_o.ovf     = ovf_n;
    push_data_o.few     = !ovf_n && (cnt_n < CountW'(MinVertices));
  end

endmodule

// File: rtl/ppia_fifo.sv
// Short request queue between front and back end.
// Depends on ppia_pkg.
module ppia_fifo (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        push_i,
  input  ppia_pkg::entry_t            push_data_i,
  output logic                        full_o,
  input  logic                        pop_i,
  output logic                        pop_valid_o,
  output ppia_pkg::entry_t            pop_data_o,
  output logic [ppia_pkg::LvlW-1:0]   level_o
);
  import ppia_pkg::*;

  entry_t          slot_q [QDepth];
  logic [PtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [LvlW-1:0] lvl_q, lvl_d;

  assign full_o      = (lvl_q == LvlW'(QDepth));
  assign pop_valid_o = (lvl_q != '0);
  assign pop_data_o  = slot_q[rd_q];
  assign level_o     = lvl_q;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    lvl_d = lvl_q;
    if (push_i) begin
      wr_d = (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
    end
    case ({push_i, pop_i})
      2'b10:   lvl_d = lvl_q + 1'b1;
      2'b01:   lvl_d = lvl_q - 1'b1;
      default: lvl_d = lvl_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      lvl_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      lvl_q <= lvl_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: rtl/ppia_edge.sv
// Three-stage edge unit: crossing test by multiply-compare and shoelace term.
// Depends on ppia_pkg.
module ppia_edge (
  input  logic                 clk_i,
  input  ppia_pkg::edge_ld_t   ld_i,
  input  ppia_pkg::edge_ops_t  ops_i,
  output ppia_pkg::edge_res_t  res_o
);
  import ppia_pkg::*;

  logic signed [DiffW-1:0]  dpa_q, dsp_q, dpy_q, dbx_q;
  coord_t                   bx_q, by_q, ax_q, ay_q;
  logic                     strad1_q, spos1_q, strad2_q, spos2_q;
  logic signed [CrossW-1:0] lhs_q, rhs_q;
  logic signed [ProdW-1:0]  pba_q, pab_q;
  logic                     toggle_q;
  logic signed [TermW-1:0]  term_q;

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      dpa_q    <= DiffW'(ops_i.px) - DiffW'(ops_i.ax);
      dsp_q    <= DiffW'(ops_i.by) - DiffW'(ops_i.ay);
      dpy_q    <= DiffW'(ops_i.py) - DiffW'(ops_i.ay);
      dbx_q    <= DiffW'(ops_i.bx) - DiffW'(ops_i.ax);
      bx_q     <= ops_i.bx;
      by_q     <= ops_i.by;
      ax_q     <= ops_i.ax;
      ay_q     <= ops_i.ay;
      // edge straddles the probe row when its ends sit on opposite sides
      strad1_q <= ($signed(ops_i.ay) > $signed(ops_i.py)) !=
                  ($signed(ops_i.by) > $signed(ops_i.py));
      spos1_q  <= $signed(ops_i.by) > $signed(ops_i.ay);
    end
    if (ld_i.s2) begin
      lhs_q    <= dpa_q * dsp_q;
      rhs_q    <= dpy_q * dbx_q;
      pba_q    <= bx_q * ay_q;
      pab_q    <= ax_q * by_q;
      strad2_q <= strad1_q;
      spos2_q  <= spos1_q;
    end
    if (ld_i.s3) begin
      // sign of the span decides which way the cross-multiplied compare reads
      toggle_q <= strad2_q && (spos2_q ? (lhs_q < rhs_q) : (rhs_q < lhs_q));
      term_q   <= TermW'(pba_q) - TermW'(pab_q);
    end
  end

  assign res_o.toggle = toggle_q;
  assign res_o.term   = term_q;

endmodule

// File: rtl/ppia_back.sv
// Back end: runs the regular and closing edge units, accumulates parity and
// shoelace sum, forms the result. Depends on ppia_pkg and ppia_edge.
module ppia_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         pop_valid_i,
  input  ppia_pkg::entry_t             pop_data_i,
  output logic                         pop_o,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         inside_res_o,
  output logic [ppia_pkg::AreaW-1:0]   twice_area_o,
  output logic                         too_few_vertices_o,
  output logic                         overflow_o
);
  import ppia_pkg::*;

  logic      v1_q, v2_q, v3_q, v4_q, ov_q;
  flags_t    fl1_q, fl2_q, fl3_q;
  logic      rdy1, rdy2, rdy3, rdy4, o_rdy, go3, en_c3;
  edge_ld_t  ld;
  edge_ops_t ops_e, ops_c;
  edge_res_t res_e, res_c;

  logic signed [SumW-1:0]  sum_q, sum_d, sum_new, fin_sum_q;
  logic signed [TermW-1:0] te, tc;
  logic                    par_q, par_d, par_new;
  logic                    fin_in_q, fin_few_q, fin_ovf_q;
  logic [SumW-1:0]         mag;

  // elastic chain: each stage frees when its occupant moves on
  assign o_rdy  = !ov_q || !out_stall_i;
  assign rdy4   = !v4_q || o_rdy;
  assign go3    = v3_q && (!fl3_q.last || rdy4);
  assign rdy3   = !v3_q || go3;
  assign rdy2   = !v2_q || rdy3;
  assign rdy1   = !v1_q || rdy2;
  assign pop_o  = pop_valid_i && rdy1;

  assign ld.s1 = rdy1;
  assign ld.s2 = rdy2;
  assign ld.s3 = rdy3;

  always_comb begin
    ops_e.bx = pop_data_i.prv_x;
    ops_e.by = pop_data_i.prv_y;
    ops_e.ax = pop_data_i.cur_x;
    ops_e.ay = pop_data_i.cur_y;
    ops_e.px = pop_data_i.prb_x;
    ops_e.py = pop_data_i.prb_y;
    ops_c.bx = pop_data_i.cur_x;
    ops_c.by = pop_data_i.cur_y;
    ops_c.ax = pop_data_i.fst_x;
    ops_c.ay = pop_data_i.fst_y;
    ops_c.px = pop_data_i.prb_x;
    ops_c.py = pop_data_i.prb_y;
  end

  ppia_edge u_edge_reg (
    .clk_i (clk_i),
    .ld_i  (ld),
    .ops_i (ops_e),
    .res_o (res_e)
  );

  ppia_edge u_edge_close (
    .clk_i (clk_i),
    .ld_i  (ld),
    .ops_i (ops_c),
    .res_o (res_c)
  );

  assign en_c3   = fl3_q.last && !fl3_q.few && !fl3_q.ovf;
  assign te      = fl3_q.edge_en ? res_e.term : '0;
  assign tc      = en_c3 ? res_c.term : '0;
  assign sum_new = sum_q + SumW'(te) + SumW'(tc);
  assign par_new = par_q ^ (fl3_q.edge_en && res_e.toggle) ^ (en_c3 && res_c.toggle);

  always_comb begin
    sum_d = sum_q;
    par_d = par_q;
    if (go3) begin
      if (fl3_q.last) begin
        sum_d = '0;
        par_d = 1'b0;
      end else begin
        sum_d = sum_new;
        par_d = par_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      v4_q  <= 1'b0;
      ov_q  <= 1'b0;
      sum_q <= '0;
      par_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= pop_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= go3 && fl3_q.last;
      if (o_rdy) ov_q <= v4_q;
      sum_q <= sum_d;
      par_q <= par_d;
    end
  end

  always_comb begin
    mag = fin_sum_q[SumW-1] ? SumW'(-fin_sum_q) : SumW'(fin_sum_q);
  end

  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      fl1_q.edge_en <= pop_data_i.edge_en;
      fl1_q.last    <= pop_data_i.last;
      fl1_q.few     <= pop_data_i.few;
      fl1_q.ovf     <= pop_data_i.ovf;
    end
    if (rdy2) fl2_q <= fl1_q;
    if (rdy3) fl3_q <= fl2_q;
    if (rdy4) begin
      fin_sum_q <= sum_new;
      fin_in_q  <= par_new && en_c3;
      fin_few_q <= fl3_q.few;
      fin_ovf_q <= fl3_q.ovf;
    end
    if (o_rdy) begin
      inside_res_o       <= fin_in_q;
      too_few_vertices_o <= fin_few_q;
      overflow_o         <= fin_ovf_q;
      if (fin_few_q || fin_ovf_q) begin
        twice_area_o <= '0;
      end else if (mag[SumW-1]) begin
        twice_area_o <= '1;  // saturate
      end else begin
        twice_area_o <= mag[AreaW-1:0];
      end
    end
  end

  assign out_valid_o = ov_q;

endmodule

// File: rtl/polygon_point_inclusion_and_area_top.sv
// Top level: point-in-outline crossing test with doubled shoelace area.
// Depends on ppia_pkg, ppia_front, ppia_fifo, ppia_back.
//
//   channel | direction | handshake                  | payload
//   --------+-----------+----------------------------+------------------------------------
//   in      | request   | in_valid_i / in_stall_o    | vertex, probe, last_vertex
//   out     | result    | out_valid_o / out_stall_i  | inside, area, too_few, overflow
//
// One vertex per cycle sustained while out_stall_i stays low; the regular and closing
// edges run on two parallel edge units, each three stages deep with 25x25 and 24x24
// multipliers. A result passes the queue, edge stages, final and output registers.
// Reset clears the outline state, the queue and all valid bits.
// A stalled result backs up the back end, then the four-entry queue, then
// in_stall_o; the front part takes requests while the queue has room.
module polygon_point_inclusion_and_area_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  ppia_pkg::coord_t           vertex_along_i,
  input  ppia_pkg::coord_t           vertex_across_i,
  input  ppia_pkg::coord_t           probe_along_i,
  input  ppia_pkg::coord_t           probe_across_i,
  input  logic                       last_vertex_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic                       inside_res_o,
  output logic [ppia_pkg::AreaW-1:0] twice_area_o,
  output logic                       too_few_vertices_o,
  output logic                       overflow_o
);
  import ppia_pkg::*;

  logic            push, full, pop, pop_valid;
  entry_t          push_data, pop_data;
  logic [LvlW-1:0] level;

  ppia_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .vertex_along_i  (vertex_along_i),
    .vertex_across_i (vertex_across_i),
    .probe_along_i   (probe_along_i),
    .probe_across_i  (probe_across_i),
    .last_vertex_i   (last_vertex_i),
    .push_o          (push),
    .push_data_o     (push_data),
    .full_i          (full)
  );

  ppia_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_valid_o (pop_valid),
    .pop_data_o  (pop_data),
    .level_o     (level)
  );

  ppia_back u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .pop_valid_i        (pop_valid),
    .pop_data_i         (pop_data),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .inside_res_o       (inside_res_o),
    .twice_area_o       (twice_area_o),
    .too_few_vertices_o (too_few_vertices_o),
    .overflow_o         (overflow_o)
  );

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(too_few_vertices_o && overflow_o))
    else $error("too_few and overflow both set");

  a_bad_outline_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (too_few_vertices_o || overflow_o) |->
      !inside_res_o && (twice_area_o == '0))
    else $error("degenerate outline reports inside or area");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("queue written while full");

  a_level_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (level != '0))
    else $error("queue read while empty");

endmodule

// File: tb/testbench.sv
`timescale 1ns / 100ps
// Testbench for polygon_point_inclusion_and_area_top: outline streams with a
// crossing-parity and shoelace-area predictor. Depends on ppia_pkg and the RTL.
module testbench;
  import ppia_pkg::*;

  localparam longint CoordMax    = (longint'(1) << (CoordW - 1)) - 1;
  localparam longint CoordMin    = -CoordMax - 1;
  localparam longint AreaMax     = (longint'(1) << AreaW) - 1;
  localparam int     RandomItems = 800;
  localparam int     DrainCycles = 24;
  localparam int     CycleLimit  = 2000000;

  typedef struct {
    coord_t along;
    coord_t across;
    coord_t p_along;
    coord_t p_across;
    logic   last;
  } vertex_req_t;

  typedef struct packed {
    logic             probe_in;
    logic [AreaW-1:0] area;
    logic             few;
    logic             ovf;
  } outline_res_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid_i = 1'b0;
  logic             in_stall_o;
  coord_t           vertex_along_i = '0;
  coord_t           vertex_across_i = '0;
  coord_t           probe_along_i = '0;
  coord_t           probe_across_i = '0;
  logic             last_vertex_i = 1'b0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic             inside_res_o;
  logic [AreaW-1:0] twice_area_o;
  logic             too_few_vertices_o;
  logic             overflow_o;

  polygon_point_inclusion_and_area_top uut (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_valid_i),
    .in_stall_o         (in_stall_o),
    .vertex_along_i     (vertex_along_i),
    .vertex_across_i    (vertex_across_i),
    .probe_along_i      (probe_along_i),
    .probe_across_i     (probe_across_i),
    .last_vertex_i      (last_vertex_i),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .inside_res_o       (inside_res_o),
    .twice_area_o       (twice_area_o),
    .too_few_vertices_o (too_few_vertices_o),
    .overflow_o         (overflow_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  vertex_req_t  vertex_queue[$];
  outline_res_t expected_results[$];

  // Outline state of the predictor
  longint      fst_x, fst_y, prv_x, prv_y, prb_x, prb_y;
  longint      shoelace;
  bit          odd_cross;
  int unsigned n_vert;
  bit          ovf_seen;

  int unsigned n_accepted, n_outlines, n_inside, n_few, n_ovf, n_checked, mismatches;
  int unsigned cycles;

  function automatic void clear_outline();
    fst_x = 0; fst_y = 0; prv_x = 0; prv_y = 0; prb_x = 0; prb_y = 0;
    shoelace = 0;
    odd_cross = 1'b0;
    n_vert = 0;
    ovf_seen = 1'b0;
  endfunction

  // Edge from b to a: parity toggle on a right-hand crossing, shoelace term.
  function automatic void cross_and_accumulate(input longint bx, input longint by,
                                               input longint ax, input longint ay);
    longint span, lhs, rhs;
    bit     right;
    if ((ay > prb_y) != (by > prb_y)) begin
      span  = by - ay;
      lhs   = (prb_x - ax) * span;
      rhs   = (prb_y - ay) * (bx - ax);
      right = (span > 0) ? (lhs < rhs) : (rhs < lhs);
      if (right) odd_cross = !odd_cross;
    end
    shoelace += bx * ay - ax * by;
  endfunction

  function automatic void outline_step(input vertex_req_t v);
    outline_res_t r;
    longint       mag;
    if (!ovf_seen) begin
      if (n_vert == 0) begin
        fst_x = longint'(v.along);
        fst_y = longint'(v.across);
        prb_x = longint'(v.p_along);
        prb_y = longint'(v.p_across);
      end else if (n_vert < MaxVertices) begin
        cross_and_accumulate(prv_x, prv_y, longint'(v.along), longint'(v.across));
      end
      n_vert++;
      if (n_vert > MaxVertices) begin
        ovf_seen = 1'b1;
      end else begin
        prv_x = longint'(v.along);
        prv_y = longint'(v.across);
      end
    end
    if (v.last) begin
      r = '0;
      if (ovf_seen) begin
        r.ovf = 1'b1;
        n_ovf++;
      end else if (n_vert < MinVertices) begin
        r.few = 1'b1;
        n_few++;
      end else begin
        cross_and_accumulate(prv_x, prv_y, fst_x, fst_y);
        r.probe_in = odd_cross;
        mag = (shoelace < 0) ? -shoelace : shoelace;
        r.area = (mag > AreaMax) ? AreaMax[AreaW-1:0] : mag[AreaW-1:0];
        if (odd_cross) n_inside++;
      end
      expected_results.insert(expected_results.size(), r);
      n_outlines++;
      clear_outline();
    end
  endfunction

  // ---------------- stimulus ----------------
  function automatic longint rnd_coord();
    return longint'(coord_t'($urandom));
  endfunction

  function automatic longint pick_coord(input int unsigned style, input longint ctr,
                                        input longint span);
    longint v;
    case (style)
      0:       v = ctr + longint'($urandom_range(0, 32'(2 * span))) - span;
      1:       v = rnd_coord();
      default: v = ctr + (longint'($urandom_range(0, 4)) - 2) * span;
    endcase
    if ($urandom_range(0, 31) == 0) v = $urandom_range(0, 1) ? CoordMax : CoordMin;
    if (v > CoordMax) v = CoordMax;
    if (v < CoordMin) v = CoordMin;
    return v;
  endfunction

  task automatic add_vertex(input longint x, input longint y, input longint px,
                            input longint py, input logic last);
    vertex_req_t v;
    v.along    = coord_t'(x);
    v.across   = coord_t'(y);
    v.p_along  = coord_t'(px);
    v.p_across = coord_t'(py);
    v.last     = last;
    vertex_queue.insert(vertex_queue.size(), v);
  endtask

  // Later vertices carry a probe the block must ignore
  task automatic add_tail(input longint x, input longint y, input logic last);
    add_vertex(x, y, rnd_coord(), rnd_coord(), last);
  endtask

  task automatic add_random_outline(output int unsigned n);
    int unsigned sel, style;
    longint      ctr_x, ctr_y, span;
    sel = $urandom_range(0, 99);
    if (sel < 10)      n = $urandom_range(1, 2);
    else if (sel < 80) n = $urandom_range(3, 8);
    else if (sel < 95) n = $urandom_range(9, 24);
    else               n = $urandom_range(25, 64);
    style = $urandom_range(0, 2);
    span  = longint'(1) << $urandom_range(1, 22);
    ctr_x = rnd_coord() / 2;
    ctr_y = rnd_coord() / 2;
    for (int k = 0; k < n; k++) begin
      if (k == 0)
        add_vertex(pick_coord(style, ctr_x, span), pick_coord(style, ctr_y, span),
                   pick_coord(style, ctr_x, span), pick_coord(style, ctr_y, span), n == 1);
      else
        add_tail(pick_coord(style, ctr_x, span), pick_coord(style, ctr_y, span), k == n - 1);
    end
  endtask

  // ---------------- driver ----------------
  vertex_req_t cur_req;
  int unsigned gap_left, in_calm_left, in_sel;
  bit          in_calm;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        outline_step(cur_req);
        n_accepted <= n_accepted + 1;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid_i <= 1'b0;
        end else if (vertex_queue.size() != 0) begin
          cur_req = vertex_queue.pop_front();
          vertex_along_i  <= cur_req.along;
          vertex_across_i <= cur_req.across;
          probe_along_i   <= cur_req.p_along;
          probe_across_i  <= cur_req.p_across;
          last_vertex_i   <= cur_req.last;
          in_valid_i      <= 1'b1;
          if (in_calm_left == 0) begin
            in_calm      = ($urandom_range(0, 3) == 0);
            in_calm_left = $urandom_range(20, 200);
          end else begin
            in_calm_left--;
          end
          in_sel   = $urandom_range(0, 99);
          gap_left = (in_calm || in_sel < 55) ? 0 :
                     (in_sel < 92) ? $urandom_range(1, 3) : $urandom_range(8, 40);
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // ---------------- long receiver hold-off ----------------
  int unsigned hold_left, hold_stage;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      hold_left  <= 0;
      hold_stage <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_stage == 0 && n_accepted >= 150) begin
      hold_left  <= 300;
      hold_stage <= 1;
    end else if (hold_stage == 1 && n_accepted >= 600) begin
      hold_left  <= 200;
      hold_stage <= 2;
    end
  end

  // ---------------- monitor ----------------
  int unsigned stall_left, out_calm_left, out_sel;
  bit          out_calm;
  outline_res_t want;

  task automatic report_field(input string field, input longint unsigned exp_v,
                              input longint unsigned act_v);
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch in %s of result %0d: expected 0x%0h, got 0x%0h",
               field, n_checked, exp_v, act_v);
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result: inside %0b area 0x%0h few %0b overflow %0b",
                     inside_res_o, twice_area_o, too_few_vertices_o, overflow_o);
        end else begin
          want = expected_results.pop_front();
          if (inside_res_o !== want.probe_in)
            report_field("inside_res", 64'(want.probe_in), 64'(inside_res_o));
          if (twice_area_o !== want.area)
            report_field("twice_area", 64'(want.area), 64'(twice_area_o));
          if (too_few_vertices_o !== want.few)
            report_field("too_few_vertices", 64'(want.few), 64'(too_few_vertices_o));
          if (overflow_o !== want.ovf)
            report_field("overflow", 64'(want.ovf), 64'(overflow_o));
        end
        n_checked++;
      end
      if (hold_left != 0) begin
        out_stall_i <= 1'b1;
      end else if (stall_left != 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        if (out_calm_left == 0) begin
          out_calm      = ($urandom_range(0, 3) == 0);
          out_calm_left = $urandom_range(50, 400);
        end else begin
          out_calm_left--;
        end
        out_sel    = $urandom_range(0, 99);
        stall_left = (out_calm || out_sel < 60) ? 0 :
                     (out_sel < 92) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycles, expected_results.size());
      $display("status: fail");
      $finish;
    end
  end

  // ---------------- sequence ----------------
  initial begin : main_seq
    int unsigned queued, n;
    clear_outline();

    // lone vertex, then a two-vertex outline
    add_vertex(CoordMax, CoordMin, CoordMin, CoordMax, 1'b1);
    add_vertex(CoordMin, CoordMin, CoordMax, CoordMin, 1'b0);
    add_tail(CoordMax, CoordMax, 1'b1);
    // full-range triangle, probe inside
    add_vertex(CoordMin, CoordMin, 4000000, -1000000, 1'b0);
    add_tail(CoordMax, CoordMin, 1'b0);
    add_tail(CoordMax, CoordMax, 1'b1);
    // clockwise square: negative shoelace sum, horizontal top and bottom
    add_vertex(-256, -256, 0, 0, 1'b0);
    add_tail(-256, 256, 1'b0);
    add_tail(256, 256, 1'b0);
    add_tail(256, -256, 1'b1);
    // diamond, probe on the row of two vertices
    add_vertex(0, -512, -100, 0, 1'b0);
    add_tail(512, 0, 1'b0);
    add_tail(0, 512, 1'b0);
    add_tail(-512, 0, 1'b1);
    // probe far to the right
    add_vertex(0, 0, 1000, 10, 1'b0);
    add_tail(100, 0, 1'b0);
    add_tail(0, 100, 1'b1);
    // probe exactly on the slanted edge
    add_vertex(0, 0, 100, 100, 1'b0);
    add_tail(200, 0, 1'b0);
    add_tail(0, 200, 1'b1);
    // all vertices coincide: zero area
    add_vertex(77, -77, 77, -77, 1'b0);
    add_tail(77, -77, 1'b0);
    add_tail(77, -77, 1'b1);

    queued = 0;
    while (queued < RandomItems) begin
      add_random_outline(n);
      queued += n;
    end

    // vertex bound: exactly at the limit, then one past it
    for (int k = 0; k < MaxVertices; k++)
      add_vertex(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), k == MaxVertices - 1);
    for (int k = 0; k <= MaxVertices; k++)
      add_vertex(rnd_coord(), rnd_coord(), rnd_coord(), rnd_coord(), k == MaxVertices);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (vertex_queue.size() != 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("%0d vertices in %0d outlines, %0d results checked in %0d cycles",
             n_accepted, n_outlines, n_checked, cycles);
    $display("outlines with probe inside %0d, too short %0d, over the bound %0d, errors %0d",
             n_inside, n_few, n_ovf, mismatches);
    if (mismatches == 0 && expected_results.size() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

// File: polygon_point_inclusion_and_area_top.f
rtl/ppia_pkg.sv
rtl/ppia_front.sv
rtl/ppia_fifo.sv
rtl/ppia_edge.sv
rtl/ppia_back.sv
rtl/polygon_point_inclusion_and_area_top.sv
tb/testbench.sv
